[rtl/core/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Result status codes, carried on the output tuser
  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_ERROR = 2'd1,
    ST_END   = 2'd2
  } status_e;

  // Input action codes, carried on the input tuser
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Configuration register indexes
  localparam logic REG_URL_SAFE       = 1'b0;
  localparam logic REG_ALLOW_TRUNCATE = 1'b1;

  // Special characters
  localparam logic [7:0] CHAR_PAD        = 8'h3D; // '='
  localparam logic [7:0] CHAR_PLUS       = 8'h2B; // '+'
  localparam logic [7:0] CHAR_SLASH      = 8'h2F; // '/'
  localparam logic [7:0] CHAR_MINUS      = 8'h2D; // '-'
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F; // '_'

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } class_t;

  // One decoded item: how many results, their kind, and the data bytes
  typedef struct packed {
    logic [1:0]                      count;
    status_e                         kind;
    logic [MaxResults-1:0][7:0]      bytes;
  } group_t;

  function automatic class_t classify(input logic [7:0] c, input logic url_safe);
    class_t r;
    r.bad = 1'b0;
    r.pad = 1'b0;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PAD) begin
      r.pad = 1'b1;
    end else if (url_safe && c == CHAR_MINUS) begin
      r.val = 6'd62;
    end else if (url_safe && c == CHAR_UNDERSCORE) begin
      r.val = 6'd63;
    end else if (!url_safe && c == CHAR_PLUS) begin
      r.val = 6'd62;
    end else if (!url_safe && c == CHAR_SLASH) begin
      r.val = 6'd63;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/core/b64d_group.sv]
// ----------------------------------------------------------------------------
// b64d_group
// Group state (pending sextets, pad flags, fill count, error latch) and the
// single-pass decode of one registered word into a result group.
// ----------------------------------------------------------------------------
module b64d_group
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic       action_i,
  input  logic [7:0] char_i,
  input  logic       url_safe_i,
  input  logic       allow_truncate_i,
  output group_t     group_o
);

  logic [2:0][5:0] sextet_q, sextet_d;
  logic [2:0]      pad_q, pad_d;
  logic [1:0]      fill_q, fill_d;
  logic            err_q, err_d;

  class_t          cls;
  logic [5:0]      s4;

  assign cls = classify(char_i, url_safe_i);
  assign s4  = cls.pad ? 6'd0 : cls.val;

  always_comb begin
    group_o       = '0;
    group_o.kind  = ST_DATA;
    sextet_d      = sextet_q;
    pad_d         = pad_q;
    fill_d        = fill_q;
    err_d         = err_q;
    if (action_i == ACT_END) begin
      group_o.count = 2'd1;
      fill_d        = 2'd0;
      err_d         = 1'b0;
      if (err_q) begin
        group_o.kind = ST_ERROR;
      end else if (fill_q == 2'd0) begin
        group_o.kind = ST_END;
      end else if (!allow_truncate_i || fill_q == 2'd1) begin
        group_o.kind = ST_ERROR;
      end else if (fill_q == 2'd2) begin
        group_o.bytes[0] = {sextet_q[0], sextet_q[1][5:4]};
      end else begin
        group_o.count    = pad_q[2] ? 2'd1 : 2'd2;
        group_o.bytes[0] = {sextet_q[0], sextet_q[1][5:4]};
        group_o.bytes[1] = {sextet_q[1][3:0], sextet_q[2][5:2]};
      end
    end else if (!err_q) begin
      if (cls.bad || (cls.pad && fill_q < 2'd2) || (fill_q == 2'd3 && pad_q[2] && !cls.pad))
      begin
        group_o.count = 2'd1;
        group_o.kind  = ST_ERROR;
        err_d         = 1'b1;
        fill_d        = 2'd0;
      end else if (fill_q < 2'd3) begin
        sextet_d[fill_q] = s4;
        pad_d[fill_q]    = cls.pad;
        fill_d           = fill_q + 2'd1;
      end else begin
        fill_d           = 2'd0;
        group_o.count    = 2'(2'd3 - {1'b0, pad_q[2]} - {1'b0, cls.pad});
        group_o.bytes[0] = {sextet_q[0], sextet_q[1][5:4]};
        group_o.bytes[1] = {sextet_q[1][3:0], sextet_q[2][5:2]};
        group_o.bytes[2] = {sextet_q[2][1:0], s4};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      err_q  <= 1'b0;
    end else if (advance_i) begin
      fill_q <= fill_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sextet_q <= sextet_d;
      pad_q    <= pad_d;
    end
  end

endmodule

[rtl/core/b64d_outbuf.sv]
// ----------------------------------------------------------------------------
// b64d_outbuf
// Result register: holds one result group and hands its words out one per
// handshake, marking the final one with tlast.
// ----------------------------------------------------------------------------
module b64d_outbuf
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  group_t     group_i,
  output logic       free_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte[7:0]
  output logic [1:0] m_axis_tuser,   // status[1:0]
  output logic       m_axis_tlast
);

  logic [MaxResults-1:0][7:0] bytes_q;
  status_e                    kind_q;
  logic [1:0]                 rem_q;
  logic [1:0]                 idx_q;
  logic                       pop;
  logic [7:0]                 sel_byte;

  assign pop           = m_axis_tvalid && m_axis_tready;
  // Free when empty, or when the last word leaves this cycle
  assign free_o        = (rem_q == 2'd0) || (rem_q == 2'd1 && m_axis_tready);
  assign m_axis_tvalid = rem_q != 2'd0;
  assign m_axis_tlast  = rem_q == 2'd1;
  assign m_axis_tuser  = kind_q;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = bytes_q[0];
      2'd1:    sel_byte = bytes_q[1];
      default: sel_byte = bytes_q[2];
    endcase
  end

  assign m_axis_tdata = (kind_q == ST_DATA) ? sel_byte : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      idx_q  <= 2'd0;
      kind_q <= ST_DATA;
    end else if (load_i) begin
      rem_q  <= group_i.count;
      idx_q  <= 2'd0;
      kind_q <= group_i.kind;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= group_i.bytes;
    end
  end

endmodule

[rtl/core/base64_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Base64 decoder, one character per input word, standard or URL-safe alphabet.
// ----------------------------------------------------------------------------
// Feed one character per input word (tuser low), or an end-of-stream word
// (tuser high). Every fourth character yields one to three data bytes
// (status 0), fewer where the group ends in '=' padding. A bad character,
// early padding or a lone third pad yields a single error word (status 1),
// after which characters are dropped until end of stream. End of stream
// yields the bytes of a truncated group (when allow_truncate is set), an
// error word, or an end marker (status 2) when nothing is pending, and then
// returns the block to its reset state. The final word caused by each input
// word carries tlast. The block takes one word per cycle unless the result
// register is busy: a word waits in the input register, is decoded in one
// pass, and its results drain at one word per cycle while m_axis_tready is
// high, so groups of four sustain one character per clock. Program url_safe
// (address 0x0) and allow_truncate (address 0x4) only while the block idles.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_byte[7:0]
  input  logic        s_axis_tuser,   // action
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       url_safe_q, url_safe_d;
  logic       allow_truncate_q, allow_truncate_d;
  logic       in_valid_q, in_valid_d;
  logic       in_action_q;
  logic [7:0] in_char_q;
  logic       s_accept;
  logic       take;
  logic       buf_free;
  group_t     group;
  logic       cfg_write;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    url_safe_d       = url_safe_q;
    allow_truncate_d = allow_truncate_q;
    if (cfg_write) begin
      unique case (paddr[2])
        REG_URL_SAFE:       url_safe_d       = pwdata[0];
        REG_ALLOW_TRUNCATE: allow_truncate_d = pwdata[0];
        default:            url_safe_d       = url_safe_q;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[2])
      REG_URL_SAFE:       prdata[0] = url_safe_q;
      REG_ALLOW_TRUNCATE: prdata[0] = allow_truncate_q;
      default:            prdata[0] = 1'b0;
    endcase
  end

  // Input register: advance when the held word can be decoded this cycle.
  // A word with no results never waits; one with results waits for the
  // result register to be free (empty, or its last word leaving).
  assign take          = in_valid_q && (group.count == 2'd0 || buf_free);
  assign s_axis_tready = !in_valid_q || take;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_safe_q       <= 1'b0;
      allow_truncate_q <= 1'b0;
      in_valid_q       <= 1'b0;
    end else begin
      url_safe_q       <= url_safe_d;
      allow_truncate_q <= allow_truncate_d;
      in_valid_q       <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_action_q <= s_axis_tuser;
      in_char_q   <= s_axis_tdata;
    end
  end

  b64d_group u_group (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (take),
    .action_i         (in_action_q),
    .char_i           (in_char_q),
    .url_safe_i       (url_safe_q),
    .allow_truncate_i (allow_truncate_q),
    .group_o          (group)
  );

  // Load the result register only for words that produce results
  b64d_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take && group.count != 2'd0),
    .group_i       (group),
    .free_o        (buf_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[rtl/core/b64d_checker.sv]
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the base64 stream decoder output.
// ----------------------------------------------------------------------------
module b64d_checker
  import b64d_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        pready
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  // Error and end words stand alone
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_DATA |-> m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("status word not alone or carries data");

  // No undefined status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ST_DATA || m_axis_tuser == ST_ERROR
                      || m_axis_tuser == ST_END)
    else $error("undefined status code");

  // A group continues without a gap until its last byte
  a_group_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser == ST_DATA)
    else $error("group broken before its last byte");

  // The configuration port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("configuration port stalled");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (.*);
